// File: rtl/necir_pkg.sv
`default_nettype none
package necir_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned REG_WIDTH       = 16;
  localparam int unsigned FRAME_BITS      = 32;
  localparam int unsigned APB_AW          = 5;
  localparam int unsigned APB_DW          = 32;

  localparam logic [REG_WIDTH-1:0] HDR_MARK_RST   = 16'd9000;
  localparam logic [REG_WIDTH-1:0] HDR_SPACE_RST  = 16'd4500;
  localparam logic [REG_WIDTH-1:0] BIT_MARK_RST   = 16'd562;
  localparam logic [REG_WIDTH-1:0] ONE_SPACE_RST  = 16'd1687;
  localparam logic [REG_WIDTH-1:0] ZERO_SPACE_RST = 16'd562;

  typedef enum logic [2:0] {
    REG_HDR_MARK   = 3'd0,
    REG_HDR_SPACE  = 3'd1,
    REG_BIT_MARK   = 3'd2,
    REG_ONE_SPACE  = 3'd3,
    REG_ZERO_SPACE = 3'd4
  } reg_idx_e;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } item_kind_e;

endpackage
`default_nettype wire

// File: rtl/nec_ir_frame_transmitter.sv
// NEC infrared envelope generator, one result item for every input item.
// Throughput: one item per cycle unless a result waits and the consumer stalls;
// the frame state and the result register update together in the accept cycle,
// so ticks and starts may come back to back.
// Reset: idle, no frame in progress, timing registers at standard NEC values.
`default_nettype none
module nec_ir_frame_transmitter
  import necir_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // item input
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              kind_i,
  input  wire logic [7:0]        address_i,
  input  wire logic [7:0]        command_i,
  // result output
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   ir_envelope_o,
  output logic                   busy_res_o,
  output logic                   frame_done_o,
  output logic                   rejected_o,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_HDR_MARK   = 3'd1,
    PH_HDR_SPACE  = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_TRAIL_MARK = 3'd5
  } phase_e;

  logic [REG_WIDTH-1:0] hdr_mark_q, hdr_space_q, bit_mark_q, one_space_q, zero_space_q;

  phase_e               phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] remain_q, remain_d;
  logic [5:0]           bits_left_q, bits_left_d;
  logic [FRAME_BITS-1:0] shift_q, shift_d;

  logic out_valid_q;
  logic env_q, busy_q, done_q, rej_q;
  logic env_d, done_d, rej_d;
  logic accept;
  logic busy_now;
  logic [5:0] bits_dec;

  // truncate to the counter width; a zero length still lasts one tick
  function automatic logic [COUNT_WIDTH-1:0] count_of(input logic [REG_WIDTH-1:0] r);
    logic [COUNT_WIDTH+REG_WIDTH-1:0] ext;
    logic [COUNT_WIDTH-1:0] v;
    ext = {{COUNT_WIDTH{1'b0}}, r};
    v   = ext[COUNT_WIDTH-1:0];
    return (v == '0) ? {{(COUNT_WIDTH-1){1'b0}}, 1'b1} : v;
  endfunction

  function automatic logic is_busy(input phase_e ph);
    return (ph == PH_HDR_MARK) || (ph == PH_HDR_SPACE) || (ph == PH_BIT_MARK) ||
           (ph == PH_BIT_SPACE) || (ph == PH_TRAIL_MARK);
  endfunction

  function automatic logic level_of(input phase_e ph);
    return (ph == PH_HDR_MARK) || (ph == PH_BIT_MARK) || (ph == PH_TRAIL_MARK);
  endfunction

  // configuration port
  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_mark_q   <= HDR_MARK_RST;
      hdr_space_q  <= HDR_SPACE_RST;
      bit_mark_q   <= BIT_MARK_RST;
      one_space_q  <= ONE_SPACE_RST;
      zero_space_q <= ZERO_SPACE_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HDR_MARK:   hdr_mark_q   <= pwdata[REG_WIDTH-1:0];
        REG_HDR_SPACE:  hdr_space_q  <= pwdata[REG_WIDTH-1:0];
        REG_BIT_MARK:   bit_mark_q   <= pwdata[REG_WIDTH-1:0];
        REG_ONE_SPACE:  one_space_q  <= pwdata[REG_WIDTH-1:0];
        REG_ZERO_SPACE: zero_space_q <= pwdata[REG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_HDR_MARK:   prdata[REG_WIDTH-1:0] = hdr_mark_q;
      REG_HDR_SPACE:  prdata[REG_WIDTH-1:0] = hdr_space_q;
      REG_BIT_MARK:   prdata[REG_WIDTH-1:0] = bit_mark_q;
      REG_ONE_SPACE:  prdata[REG_WIDTH-1:0] = one_space_q;
      REG_ZERO_SPACE: prdata[REG_WIDTH-1:0] = zero_space_q;
      default:        prdata = '0;
    endcase
  end

  // hold the input while a result waits and the consumer stalls
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign busy_now   = is_busy(phase_q);
  assign bits_dec   = (bits_left_q != '0) ? bits_left_q - 6'd1 : 6'd0;

  always_comb begin
    phase_d     = phase_q;
    remain_d    = remain_q;
    bits_left_d = bits_left_q;
    shift_d     = shift_q;
    env_d       = 1'b0;
    done_d      = 1'b0;
    rej_d       = 1'b0;
    if (kind_i == KIND_START) begin
      if (busy_now) begin
        rej_d = 1'b1;
        env_d = level_of(phase_q);
      end else begin
        shift_d     = {address_i, ~address_i, command_i, ~command_i};
        bits_left_d = 6'(FRAME_BITS);
        phase_d     = PH_HDR_MARK;
        remain_d    = count_of(hdr_mark_q);
        env_d       = 1'b1;
      end
    end else if (busy_now) begin
      env_d = level_of(phase_q);
      if (remain_q > {{(COUNT_WIDTH-1){1'b0}}, 1'b1}) begin
        remain_d = remain_q - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      end else begin
        case (phase_q)
          PH_HDR_MARK: begin
            phase_d  = PH_HDR_SPACE;
            remain_d = count_of(hdr_space_q);
          end
          PH_HDR_SPACE: begin
            phase_d  = PH_BIT_MARK;
            remain_d = count_of(bit_mark_q);
          end
          PH_BIT_MARK: begin
            phase_d  = PH_BIT_SPACE;
            remain_d = count_of(shift_q[FRAME_BITS-1] ? one_space_q : zero_space_q);
          end
          PH_BIT_SPACE: begin
            shift_d     = {shift_q[FRAME_BITS-2:0], 1'b0};
            bits_left_d = bits_dec;
            phase_d     = (bits_dec == '0) ? PH_TRAIL_MARK : PH_BIT_MARK;
            remain_d    = count_of(bit_mark_q);
          end
          default: begin
            phase_d  = PH_IDLE;
            remain_d = '0;
            done_d   = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      remain_q    <= '0;
      bits_left_q <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        remain_q    <= remain_d;
        bits_left_q <= bits_left_d;
        shift_q     <= shift_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      env_q  <= env_d;
      busy_q <= is_busy(phase_d);
      done_q <= done_d;
      rej_q  <= rej_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ir_envelope_o = env_q;
  assign busy_res_o    = busy_q;
  assign frame_done_o  = done_q;
  assign rejected_o    = rej_q;

endmodule
`default_nettype wire

// File: test/nec_ir_frame_transmitter_tb.sv
`timescale 1ns / 100ps
module nec_ir_frame_transmitter_tb;
  import necir_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 140;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAD_MARK,
    S_LEAD_SPACE,
    S_DATA_MARK,
    S_DATA_SPACE,
    S_STOP_MARK
  } ir_phase_e;

  typedef struct {
    item_kind_e  kind;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    int unsigned gap;
  } ir_item_t;

  typedef struct packed {
    logic env;
    logic busy;
    logic done;
    logic rej;
  } env_res_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              kind_i      = 1'b0;
  logic [7:0]        address_i   = '0;
  logic [7:0]        command_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              ir_envelope_o;
  logic              busy_res_o;
  logic              frame_done_o;
  logic              rejected_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // timing registers and frame state as the block should hold them
  logic [15:0]  timing_cfg [5];
  ir_phase_e    tx_state      = S_IDLE;
  int unsigned  ticks_left    = 0;
  logic [5:0]   bits_to_send  = '0;
  logic [31:0]  frame_word    = '0;

  ir_item_t     tx_pending [$];
  ir_item_t     tx_next;
  env_res_t     envelope_q [$];
  env_res_t     want;

  bit           tx_no_idle    = 1'b0;
  bit           rx_fast       = 1'b0;
  int unsigned  hold_ticket   = 0;
  int unsigned  hold_seen     = 0;
  int unsigned  hold_left     = 0;
  int unsigned  rx_wait       = 0;
  int unsigned  rx_calm       = 0;
  int unsigned  quiet_cycles  = 0;
  int unsigned  fail_count    = 0;
  int unsigned  items_queued  = 0;
  int unsigned  items_checked = 0;
  int unsigned  frames_sent   = 0;
  int unsigned  starts_refused = 0;
  int unsigned  settings_used = 0;

  nec_ir_frame_transmitter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .address_i     (address_i),
    .command_i     (command_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ir_envelope_o (ir_envelope_o),
    .busy_res_o    (busy_res_o),
    .frame_done_o  (frame_done_o),
    .rejected_o    (rejected_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // a zero length still lasts one tick
  function automatic int unsigned span(input logic [15:0] r);
    return (r == 16'd0) ? 1 : int'(r);
  endfunction

  function automatic logic is_mark(input ir_phase_e p);
    return (p == S_LEAD_MARK) || (p == S_DATA_MARK) || (p == S_STOP_MARK);
  endfunction

  function automatic env_res_t predict_envelope(input logic kind, input logic [7:0] a,
                                                input logic [7:0] c);
    env_res_t r;
    r = '0;
    if (kind == KIND_START) begin
      if (tx_state != S_IDLE) begin
        r.rej = 1'b1;
      end else begin
        frame_word   = {a, ~a, c, ~c};
        bits_to_send = 6'd32;
        tx_state     = S_LEAD_MARK;
        ticks_left   = span(timing_cfg[REG_HDR_MARK]);
      end
      r.env = is_mark(tx_state);
    end else if (tx_state != S_IDLE) begin
      r.env = is_mark(tx_state);
      if (ticks_left > 1) begin
        ticks_left = ticks_left - 1;
      end else begin
        case (tx_state)
          S_LEAD_MARK: begin
            tx_state   = S_LEAD_SPACE;
            ticks_left = span(timing_cfg[REG_HDR_SPACE]);
          end
          S_LEAD_SPACE: begin
            tx_state   = S_DATA_MARK;
            ticks_left = span(timing_cfg[REG_BIT_MARK]);
          end
          S_DATA_MARK: begin
            tx_state   = S_DATA_SPACE;
            ticks_left = span(frame_word[31] ? timing_cfg[REG_ONE_SPACE]
                                             : timing_cfg[REG_ZERO_SPACE]);
          end
          S_DATA_SPACE: begin
            frame_word   = frame_word << 1;
            bits_to_send = (bits_to_send != 0) ? bits_to_send - 6'd1 : 6'd0;
            tx_state     = (bits_to_send == 0) ? S_STOP_MARK : S_DATA_MARK;
            ticks_left   = span(timing_cfg[REG_BIT_MARK]);
          end
          default: begin
            tx_state   = S_IDLE;
            ticks_left = 0;
            r.done     = 1'b1;
          end
        endcase
      end
    end
    r.busy = (tx_state != S_IDLE);
    return r;
  endfunction

  // ticks from start until the trailing mark ends
  function automatic int frame_length(input logic [7:0] a, input logic [7:0] c);
    logic [31:0] w;
    int          n;
    w = {a, ~a, c, ~c};
    n = span(timing_cfg[REG_HDR_MARK]) + span(timing_cfg[REG_HDR_SPACE])
      + span(timing_cfg[REG_BIT_MARK]);
    for (int i = 0; i < 32; i++) begin
      n += span(timing_cfg[REG_BIT_MARK])
         + span(w[i] ? timing_cfg[REG_ONE_SPACE] : timing_cfg[REG_ZERO_SPACE]);
    end
    return n;
  endfunction

  task automatic check_bit(input string field, input logic want_v, input logic got_v);
    if (got_v !== want_v) begin
      fail_count++;
      $error("%s: expected %0b, got %0b", field, want_v, got_v);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      kind_i     <= KIND_TICK;
      address_i  <= '0;
      command_i  <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (tx_pending.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (tx_pending[0].gap != 0) begin
        tx_pending[0].gap = tx_pending[0].gap - 1;
        in_valid_i <= 1'b0;
      end else begin
        tx_next = tx_pending.pop_front();
        in_valid_i <= 1'b1;
        kind_i     <= tx_next.kind;
        address_i  <= tx_next.addr;
        command_i  <= tx_next.cmd;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        if (out_valid_o && !out_stall_i) begin
          if (rx_calm != 0) rx_calm = rx_calm - 1;
          else if ($urandom_range(0, 39) == 0) rx_calm = 30;
          rx_wait = (rx_fast || rx_calm != 0) ? 0 : $urandom_range(0, 19);
        end else if (rx_wait != 0) begin
          rx_wait = rx_wait - 1;
        end
        out_stall_i <= (rx_wait != 0);
      end
    end
  end

  // monitor: predict on accepted items, then check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        envelope_q.push_back(predict_envelope(kind_i, address_i, command_i));
      if (out_valid_o && !out_stall_i) begin
        if (envelope_q.size() == 0) begin
          fail_count++;
          $error("result item with no item pending");
        end else begin
          want = envelope_q.pop_front();
          items_checked++;
          if (want.done) frames_sent++;
          if (want.rej) starts_refused++;
          check_bit("ir_envelope", want.env, ir_envelope_o);
          check_bit("busy_res", want.busy, busy_res_o);
          check_bit("frame_done", want.done, frame_done_o);
          check_bit("rejected", want.rej, rejected_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic push_item(input item_kind_e k, input logic [7:0] a, input logic [7:0] c);
    ir_item_t it;
    it.kind = k;
    it.addr = a;
    it.cmd  = c;
    it.gap  = tx_no_idle ? 0 : $urandom_range(0, 19);
    tx_pending.push_back(it);
    items_queued++;
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) push_item(KIND_TICK, 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_quiet();
    while (tx_pending.size() != 0 || in_valid_i || envelope_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [15:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    timing_cfg[idx] = val;
  endtask

  task automatic load_timing(input logic [15:0] hm, input logic [15:0] hs,
                             input logic [15:0] bm, input logic [15:0] one,
                             input logic [15:0] zero);
    wait_quiet();
    apb_write(REG_HDR_MARK, hm);
    apb_write(REG_HDR_SPACE, hs);
    apb_write(REG_BIT_MARK, bm);
    apb_write(REG_ONE_SPACE, one);
    apb_write(REG_ZERO_SPACE, zero);
    settings_used++;
    @(negedge clk_i);
  endtask

  // tick the frame in progress to its end at full rate
  task automatic flush_frame();
    tx_no_idle = 1'b1;
    rx_fast    = 1'b1;
    wait_quiet();
    while (tx_state != S_IDLE) begin
      push_ticks(64);
      wait_quiet();
    end
    tx_no_idle = 1'b0;
    rx_fast    = 1'b0;
  endtask

  // mostly complete frames with random content, some cut short, some with a
  // start dropped into the middle, and a little noise between them
  task automatic run_frames(input int unsigned n_items);
    int unsigned stop_at;
    int          len;
    int          cut;
    logic [7:0]  a;
    logic [7:0]  c;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) begin
      tx_no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        push_ticks($urandom_range(1, 6));
        if ($urandom_range(0, 1) != 0) push_item(KIND_START, 8'($urandom), 8'($urandom));
      end else begin
        a   = 8'($urandom);
        c   = 8'($urandom);
        len = frame_length(a, c);
        push_item(KIND_START, a, c);
        if ($urandom_range(0, 4) == 0) len = $urandom_range(1, len);
        else len += $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) begin
          cut = $urandom_range(0, len);
          push_ticks(cut);
          push_item(KIND_START, 8'($urandom), 8'($urandom));
          push_ticks(len - cut);
        end else begin
          push_ticks(len);
        end
      end
      if ($urandom_range(0, 9) == 0) wait_quiet();
    end
    tx_no_idle = 1'b0;
  endtask

  initial begin
    timing_cfg[REG_HDR_MARK]   = HDR_MARK_RST;
    timing_cfg[REG_HDR_SPACE]  = HDR_SPACE_RST;
    timing_cfg[REG_BIT_MARK]   = BIT_MARK_RST;
    timing_cfg[REG_ONE_SPACE]  = ONE_SPACE_RST;
    timing_cfg[REG_ZERO_SPACE] = ZERO_SPACE_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ticks while idle right after reset
    push_item(KIND_TICK, 8'h00, 8'h00);
    push_item(KIND_TICK, 8'hFF, 8'hFF);
    wait_quiet();

    // zero lengths collapse each phase to one tick
    load_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    flush_frame();
    run_frames(PHASE_ITEMS);
    flush_frame();

    load_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    run_frames(PHASE_ITEMS);
    flush_frame();

    for (int p = 0; p < 4; p++) begin
      load_timing(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                  16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
                  16'($urandom_range(0, 4)));
      // back up the block with a long receiver hold while items keep coming
      if (p == 1) hold_ticket = hold_ticket + 1;
      run_frames(PHASE_ITEMS);
      flush_frame();
    end

    // longest lengths; the frame is still in its leading mark at the end
    load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(KIND_START, 8'($urandom), 8'($urandom));
    push_ticks(30);
    push_item(KIND_START, 8'($urandom), 8'($urandom));
    push_ticks(30);
    wait_quiet();

    repeat (8) @(posedge clk_i);
    if (envelope_q.size() != 0) begin
      fail_count++;
      $error("%0d expected result items never arrived", envelope_q.size());
    end
    $display("covered %0d items over %0d timing settings", items_checked, settings_used);
    $display("%0d frames completed, %0d starts refused while busy",
             frames_sent, starts_refused);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/necir_pkg.sv
rtl/nec_ir_frame_transmitter.sv
test/nec_ir_frame_transmitter_tb.sv
